>>> hdl/bitbang_uart_line_model_macros.svh
// Assertion macros for the bit-banged serial line model.
`ifndef BITBANG_UART_LINE_MODEL_MACROS_SVH
`define BITBANG_UART_LINE_MODEL_MACROS_SVH
`ifndef SYNTHESIS
`define BBUL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BBUL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BBUL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BBUL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/bbul_pkg.sv
// Types and constants shared by the serial line model sequencer and datapath.
package bbul_pkg;

    localparam int PER_W = 48;
    localparam int TS_W  = 64;
    localparam int PC_W  = 4;

    localparam logic [3:0] TX_FRAME_BITS = 4'd9;
    localparam logic [3:0] RX_FRAME_BITS = 4'd10;
    localparam logic [4:0] TX_SLACK      = 5'd5;
    localparam logic [1:0] RX_FRAME_MARK = 2'b11;

    localparam logic [1:0] ACT_LOW   = 2'd0;
    localparam logic [1:0] ACT_HIGH  = 2'd1;
    localparam logic [1:0] ACT_RX    = 2'd2;
    localparam logic [1:0] ACT_OTHER = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_IDLE   = 4'd1;
    localparam logic [3:0] OP_CANCEL = 4'd2;
    localparam logic [3:0] OP_LOAD_D = 4'd3;
    localparam logic [3:0] OP_COUNT  = 4'd4;
    localparam logic [3:0] OP_SHIFT  = 4'd5;
    localparam logic [3:0] OP_FINISH = 4'd6;
    localparam logic [3:0] OP_ABORT  = 4'd7;
    localparam logic [3:0] OP_START  = 4'd8;
    localparam logic [3:0] OP_RX     = 4'd9;
    localparam logic [3:0] OP_EMIT   = 4'd10;

    // jump conditions
    localparam logic [3:0] C_NEXT       = 4'd0;
    localparam logic [3:0] C_ALWAYS     = 4'd1;
    localparam logic [3:0] C_NO_IN      = 4'd2;
    localparam logic [3:0] C_IS_RX      = 4'd3;
    localparam logic [3:0] C_IS_OTHER   = 4'd4;
    localparam logic [3:0] C_TX_START   = 4'd5;
    localparam logic [3:0] C_TX_IDLE    = 4'd6;
    localparam logic [3:0] C_CNT_MORE   = 4'd7;
    localparam logic [3:0] C_SLOW       = 4'd8;
    localparam logic [3:0] C_SHIFT_MORE = 4'd9;
    localparam logic [3:0] C_OUT_BUSY   = 4'd10;

    typedef struct packed {
        logic [3:0]      op;
        logic [3:0]      cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic no_in;
        logic is_rx;
        logic is_other;
        logic tx_start;
        logic tx_idle;
        logic cnt_more;
        logic slow;
        logic shift_more;
        logic out_busy;
    } t_flags;

    typedef struct packed {
        logic [7:0] rx_finished_char;
        logic       rx_done;
        logic       framing_error;
        logic [7:0] tx_byte;
        logic       tx_done;
        logic       read_data;
    } t_result;

endpackage

>>> hdl/bbul_seq.sv
// Microcode sequencer: program ROM, step counter and conditional jumps.
module bbul_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bbul_pkg::t_flags i_flags,
    output bbul_pkg::t_ctrl  o_ctrl
);
    import bbul_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           ctrl;
    logic            take;

    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        unique case (pc)
            4'd0:    w = '{op: OP_IDLE,   cond: C_NO_IN,      target: 4'd0};
            4'd1:    w = '{op: OP_NOP,    cond: C_IS_RX,      target: 4'd12};
            4'd2:    w = '{op: OP_NOP,    cond: C_IS_OTHER,   target: 4'd15};
            4'd3:    w = '{op: OP_NOP,    cond: C_TX_START,   target: 4'd11};
            4'd4:    w = '{op: OP_CANCEL, cond: C_TX_IDLE,    target: 4'd15};
            4'd5:    w = '{op: OP_LOAD_D, cond: C_NEXT,       target: 4'd0};
            4'd6:    w = '{op: OP_COUNT,  cond: C_CNT_MORE,   target: 4'd6};
            4'd7:    w = '{op: OP_NOP,    cond: C_SLOW,       target: 4'd10};
            4'd8:    w = '{op: OP_SHIFT,  cond: C_SHIFT_MORE, target: 4'd8};
            4'd9:    w = '{op: OP_FINISH, cond: C_ALWAYS,     target: 4'd15};
            4'd10:   w = '{op: OP_ABORT,  cond: C_ALWAYS,     target: 4'd15};
            4'd11:   w = '{op: OP_START,  cond: C_ALWAYS,     target: 4'd15};
            4'd12:   w = '{op: OP_RX,     cond: C_ALWAYS,     target: 4'd15};
            4'd15:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,   target: 4'd15};
            default: w = '{op: OP_NOP,    cond: C_ALWAYS,     target: 4'd0};
        endcase
        return w;
    endfunction

    assign ctrl   = ucode(r_pc);
    assign o_ctrl = ctrl;

    always_comb begin
        unique case (ctrl.cond)
            C_NEXT:       take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_IN:      take = i_flags.no_in;
            C_IS_RX:      take = i_flags.is_rx;
            C_IS_OTHER:   take = i_flags.is_other;
            C_TX_START:   take = i_flags.tx_start;
            C_TX_IDLE:    take = i_flags.tx_idle;
            C_CNT_MORE:   take = i_flags.cnt_more;
            C_SLOW:       take = i_flags.slow;
            C_SHIFT_MORE: take = i_flags.shift_more;
            C_OUT_BUSY:   take = i_flags.out_busy;
            default:      take = 1'b0;
        endcase
        // EMIT sits at the last step, so falling through wraps to IDLE
        n_pc = take ? ctrl.target : r_pc + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> hdl/bbul_dp.sv
// Datapath: transmit and receive line state driven by microcode operations.
module bbul_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bbul_pkg::t_ctrl            i_ctrl,
    input  logic [bbul_pkg::PER_W-1:0] i_period,
    input  logic                       i_in_valid,
    input  logic [1:0]                 i_action,
    input  logic [bbul_pkg::TS_W-1:0]  i_timestamp,
    input  logic [7:0]                 i_fill_char,
    input  logic                       i_out_busy,
    output logic                       o_in_ready,
    output logic                       o_emit,
    output bbul_pkg::t_result          o_result,
    output bbul_pkg::t_flags           o_flags
);
    import bbul_pkg::*;

    logic [1:0]      r_action, n_action;
    logic [TS_W-1:0] r_ts, n_ts;
    logic [7:0]      r_fill, n_fill;
    logic [TS_W-1:0] r_d, n_d;
    logic [3:0]      r_bits, n_bits;
    t_result         r_res, n_res;

    logic            r_tx_active, n_tx_active;
    logic [3:0]      r_tx_count, n_tx_count;
    logic [8:0]      r_tx_shift, n_tx_shift;
    logic            r_tx_prev, n_tx_prev;
    logic [TS_W-1:0] r_tx_sample, n_tx_sample;

    logic [3:0]      r_rx_count, n_rx_count;
    logic [10:0]     r_rx_shift, n_rx_shift;
    logic [7:0]      r_rx_pend, n_rx_pend;
    logic [TS_W-1:0] r_rx_due, n_rx_due;

    logic [TS_W-1:0] per64;
    logic            d_ge;
    logic [4:0]      limit;
    logic            level;
    logic            early;
    logic [8:0]      fin_shift;
    logic            reload;
    logic [10:0]     eff_shift;
    logic [3:0]      eff_count;
    logic [TS_W-1:0] base;

    assign per64 = {{(TS_W-PER_W){1'b0}}, i_period};
    assign d_ge  = r_d >= per64;
    assign limit = {1'b0, r_tx_count} + TX_SLACK;
    assign level = (r_action == ACT_HIGH);

    assign early     = (r_tx_count == 4'd1) && level;
    assign fin_shift = early ? {1'b1, r_tx_shift[8:1]} : r_tx_shift;

    assign reload    = (r_rx_count == 4'd0);
    assign eff_shift = reload ? {RX_FRAME_MARK, r_fill, 1'b0} : r_rx_shift;
    assign eff_count = reload ? RX_FRAME_BITS : r_rx_count;
    assign base      = reload ? r_ts : r_rx_due;

    assign o_in_ready = (i_ctrl.op == OP_IDLE);
    assign o_emit     = (i_ctrl.op == OP_EMIT) && !i_out_busy;
    assign o_result   = r_res;

    always_comb begin
        o_flags.no_in      = !i_in_valid;
        o_flags.is_rx      = (r_action == ACT_RX);
        o_flags.is_other   = (r_action == ACT_OTHER);
        o_flags.tx_start   = (r_action == ACT_LOW) && !r_tx_active;
        o_flags.tx_idle    = !r_tx_active;
        o_flags.cnt_more   = d_ge && (({1'b0, r_bits} + 5'd1) <= limit);
        o_flags.slow       = {1'b0, r_bits} > limit;
        o_flags.shift_more = (r_bits > 4'd1) && (r_tx_count > 4'd1);
        o_flags.out_busy   = i_out_busy;
    end

    always_comb begin
        n_action    = r_action;
        n_ts        = r_ts;
        n_fill      = r_fill;
        n_d         = r_d;
        n_bits      = r_bits;
        n_res       = r_res;
        n_tx_active = r_tx_active;
        n_tx_count  = r_tx_count;
        n_tx_shift  = r_tx_shift;
        n_tx_prev   = r_tx_prev;
        n_tx_sample = r_tx_sample;
        n_rx_count  = r_rx_count;
        n_rx_shift  = r_rx_shift;
        n_rx_pend   = r_rx_pend;
        n_rx_due    = r_rx_due;
        unique case (i_ctrl.op)
            OP_IDLE: begin
                if (i_in_valid) begin
                    n_action = i_action;
                    n_ts     = i_timestamp;
                    n_fill   = i_fill_char;
                    n_res    = '0;
                end
            end
            OP_CANCEL: begin
                n_rx_count = '0;
            end
            OP_LOAD_D: begin
                n_d    = (r_ts < r_tx_sample) ? '0 : r_ts - r_tx_sample;
                n_bits = '0;
            end
            OP_COUNT: begin
                if (d_ge) begin
                    n_d    = r_d - per64;
                    n_bits = r_bits + 4'd1;
                end
            end
            OP_SHIFT: begin
                if (r_bits != 4'd0 && r_tx_count != 4'd0) begin
                    n_tx_shift  = {r_tx_prev, r_tx_shift[8:1]};
                    n_tx_count  = r_tx_count - 4'd1;
                    n_tx_sample = r_tx_sample + per64;
                    n_bits      = r_bits - 4'd1;
                end
            end
            OP_FINISH: begin
                n_tx_shift = fin_shift;
                n_tx_prev  = level;
                if (early || r_tx_count == 4'd0) begin
                    n_tx_count          = '0;
                    n_tx_active         = 1'b0;
                    n_res.tx_done       = 1'b1;
                    n_res.tx_byte       = fin_shift[7:0];
                    n_res.framing_error = !fin_shift[8];
                end
            end
            OP_ABORT: begin
                n_tx_active = 1'b0;
            end
            OP_START: begin
                n_tx_active = 1'b1;
                n_tx_count  = TX_FRAME_BITS;
                n_tx_shift  = '0;
                n_tx_sample = r_ts + (per64 >> 1);
            end
            OP_RX: begin
                if (r_ts >= r_rx_due) begin
                    if (reload) begin
                        n_res.rx_done          = 1'b1;
                        n_res.rx_finished_char = r_rx_pend;
                        n_rx_pend              = r_fill;
                    end
                    n_res.read_data = eff_shift[0];
                    n_rx_shift      = eff_shift >> 1;
                    n_rx_count      = eff_count - 4'd1;
                    n_rx_due        = base + per64;
                end else begin
                    n_res.read_data = r_rx_shift[0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_ts     <= n_ts;
        r_fill   <= n_fill;
        r_d      <= n_d;
        r_bits   <= n_bits;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_active <= 1'b0;
            r_tx_count  <= '0;
            r_tx_shift  <= '0;
            r_tx_prev   <= 1'b0;
            r_tx_sample <= '0;
            r_rx_count  <= '0;
            r_rx_shift  <= '0;
            r_rx_pend   <= '0;
            r_rx_due    <= '0;
        end else begin
            r_tx_active <= n_tx_active;
            r_tx_count  <= n_tx_count;
            r_tx_shift  <= n_tx_shift;
            r_tx_prev   <= n_tx_prev;
            r_tx_sample <= n_tx_sample;
            r_rx_count  <= n_rx_count;
            r_rx_shift  <= n_rx_shift;
            r_rx_pend   <= n_rx_pend;
            r_rx_due    <= n_rx_due;
        end
    end

endmodule

>>> hdl/bitbang_uart_line_model.sv
// A transfer is accepted in the idle step. Receive reads and other accesses then go
// straight to emit; transmit accesses that neither start a frame nor find the
// transmitter idle run the bit-count loop (one compare-subtract per cycle), then the
// shift loop, or abort if too slow. A new transfer waits for the emit, which itself
// waits while the output register is full. Reset (i_rst_n low, synchronous) clears
// all line state, sets the bit period to its default and empties the output register.
module bitbang_uart_line_model (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_wdata,   // bit_period
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,     // timestamp[63:0], fill_char[71:64]
    input  logic [1:0]  i_s_tuser,     // action[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata      // read_data[0], tx_done[1], tx_byte[9:2],
                                       // framing_error[10], rx_done[11],
                                       // rx_finished_char[19:12], zero[23:20]
);
    import bbul_pkg::*;

    localparam logic [PER_W-1:0] PERIOD_RESET = 48'd429496729600;

    logic [PER_W-1:0] r_period;
    logic [PER_W-1:0] period;
    logic             r_out_valid;
    logic [23:0]      r_out_data;
    logic             out_busy;
    logic             emit;
    t_result          result;
    t_ctrl            ctrl;
    t_flags           flags;

    assign period   = (r_period == '0) ? {{(PER_W-1){1'b0}}, 1'b1} : r_period;
    assign out_busy = r_out_valid && !i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    bbul_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    bbul_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_period    (period),
        .i_in_valid  (i_s_tvalid),
        .i_action    (i_s_tuser),
        .i_timestamp (i_s_tdata[63:0]),
        .i_fill_char (i_s_tdata[71:64]),
        .i_out_busy  (out_busy),
        .o_in_ready  (o_s_tready),
        .o_emit      (emit),
        .o_result    (result),
        .o_flags     (flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= {4'd0, result};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`include "bitbang_uart_line_model_macros.svh"

    `BBUL_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `BBUL_ASSERT_IMPL(a_tx_rx_excl, i_clk, i_rst_n, o_m_tvalid, !(o_m_tdata[1] && o_m_tdata[11]))
    `BBUL_ASSERT_IMPL(a_fe_needs_done, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[10], o_m_tdata[1])

endmodule
